@@ hw/rtl/bra_pkg.sv @@
package bra_pkg;

    localparam int MAX_SLOTS     = 256;
    localparam int MAX_SCATTERED = 16;
    localparam int MAX_COUNT     = 64;

    // The bitmap is kept as words of WORD_W bits, one word per memory entry.
    localparam int WORD_W    = 8;
    localparam int NUM_WORDS = MAX_SLOTS / WORD_W;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int WADDR_W   = $clog2(NUM_WORDS);
    localparam int SLOT_W    = WADDR_W + BIT_W;
    localparam int ISSUE_W   = WADDR_W + 1;

    // Fixed field widths.
    localparam int POOL_W   = 9;
    localparam int CNT_W    = 7;
    localparam int OP_W     = 2;
    localparam int REL_W    = 16;
    localparam int STAT_W   = 2;
    localparam int INDEX_W  = 8;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_CONTIG  = 2'd0,
        OP_SCATTER = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOSPACE   = 2'd1,
        STAT_NOTPERM   = 2'd2,
        STAT_OVERLIMIT = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCATTER_LOCK = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT_RD,
        S_COMMIT_LOAD,
        S_COMMIT_BIT,
        S_REL_RD,
        S_REL_WR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic              contig;
        logic [CNT_W-1:0]  cnt;
        logic [POOL_W-1:0] pool;
    } scan_ctl_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] start;
    } scan_res_t;

endpackage

@@ hw/rtl/bra_cmd_if.sv @@
interface bra_cmd_if import bra_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [CNT_W-1:0]   count;
    logic [REL_W-1:0]   release_index;

    modport source (output valid, output opcode, output count, output release_index,
                    input ready);
    modport sink (input valid, input opcode, input count, input release_index,
                  output ready);
endinterface

@@ hw/rtl/bra_res_if.sv @@
interface bra_res_if import bra_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [INDEX_W-1:0] slot_index;
    logic               index_valid;
    logic               last;

    modport source (output valid, output status, output slot_index, output index_valid,
                    output last, input ready);
    modport sink (input valid, input status, input slot_index, input index_valid,
                  input last, output ready);
endinterface

@@ hw/rtl/bitmap_resource_allocator.sv @@
// Bitmap resource allocator with first-fit search over a pool of up to 256 slots.
// Commands arrive on the cmd channel (opcode, count, release_index) and results
// leave on the res channel, one transfer per assigned slot, the final one marked
// by last. A failed assign, a zero-count assign and a release each give a single
// result; opcode 3 gives none. Registers are written through cfg_we/cfg_index/
// cfg_data; the user must write them only while no command is in progress, as
// the block itself does not enforce this. One command is handled at a time.
// An assign reads the bitmap one 8-bit word per cycle from a single memory;
// a successful assign then marks and reports its slots word by word, with a
// read, a load and a bit-marking step per word. A release inside the pool reads
// the bitmap word and writes it back with the slot cleared before its result.
// After reset every slot is free and the registers hold pool_size 256 and
// scatter_lock 0; per-word valid bits make the bitmap read as free at once, so
// there is no clearing pass. When the receiver stalls, the result register holds
// its transfer and the block waits; a new command is taken while the final
// result of the previous one still waits in that register.
module bitmap_resource_allocator import bra_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    bra_cmd_if.sink              cmd,
    bra_res_if.source            res
);

    state_t              state_reg,        state_next;
    logic [POOL_W-1:0]   pool_size_reg;
    logic                scatter_lock_reg;
    logic                is_contig_reg,    is_contig_next;
    logic [CNT_W-1:0]    cnt_reg,          cnt_next;
    logic [SLOT_W-1:0]   lo_reg,           lo_next;
    logic [WADDR_W-1:0]  wi_reg,           wi_next;
    logic [WORD_W-1:0]   work_reg,         work_next;
    logic [CNT_W-1:0]    remain_reg,       remain_next;
    logic [SLOT_W-1:0]   rel_reg,          rel_next;
    logic [STAT_W-1:0]   status_reg,       status_next;
    logic [ISSUE_W-1:0]  issue_reg,        issue_next;
    logic                pend_reg,         pend_next;
    logic [WADDR_W-1:0]  pend_word_reg;
    logic                last_proc_reg;
    logic                out_valid_reg,    out_valid_next;
    logic [STAT_W-1:0]   out_status_reg,   out_status_next;
    logic [INDEX_W-1:0]  out_index_reg,    out_index_next;
    logic                out_ivalid_reg,   out_ivalid_next;
    logic                out_last_reg,     out_last_next;

    logic [POOL_W-1:0]   pool_eff;
    logic                out_free;
    logic [WADDR_W-1:0]  rd_addr;
    logic [WORD_W-1:0]   rd_data;
    logic                wr_en;
    logic [WADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic                scan_clear;
    scan_ctl_t           scan_ctl;
    scan_res_t           scan_res;
    logic [WORD_W-1:0]   pick_mask;
    logic                pick_any;
    logic [BIT_W-1:0]    pick_bit;

    assign pool_eff = (pool_size_reg > POOL_W'(MAX_SLOTS)) ? POOL_W'(MAX_SLOTS) : pool_size_reg;
    assign out_free = !out_valid_reg || res.ready;

    assign scan_ctl.contig = is_contig_reg;
    assign scan_ctl.cnt    = cnt_reg;
    assign scan_ctl.pool   = pool_eff;

    bra_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bra_scan u_scan
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (scan_clear),
        .word_en  (pend_reg),
        .word_idx (pend_word_reg),
        .word     (rd_data),
        .ctl      (scan_ctl),
        .res      (scan_res)
    );

    // Slots of the current word still to be taken: free, inside the pool and
    // at or above the start of the chosen run. The lowest one goes next.
    always_comb
    begin
        logic [POOL_W-1:0] slot;
        pick_any = 1'b0;
        pick_bit = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            slot = POOL_W'({wi_reg, BIT_W'(j)});
            pick_mask[j] = !work_reg[j] && (slot < pool_eff)
                           && (slot[SLOT_W-1:0] >= lo_reg);
        end
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (pick_mask[j])
            begin
                pick_any = 1'b1;
                pick_bit = BIT_W'(j);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        is_contig_next  = is_contig_reg;
        cnt_next        = cnt_reg;
        lo_next         = lo_reg;
        wi_next         = wi_reg;
        work_next       = work_reg;
        remain_next     = remain_reg;
        rel_next        = rel_reg;
        status_next     = status_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        out_valid_next  = out_valid_reg && !res.ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_ivalid_next = out_ivalid_reg;
        out_last_next   = out_last_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = wi_reg;
        wr_data         = work_reg;
        scan_clear      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    is_contig_next = (cmd.opcode == OP_CONTIG);
                    cnt_next       = cmd.count;
                    issue_next     = '0;
                    scan_clear     = 1'b1;
                    case (cmd.opcode)
                        OP_RELEASE:
                        begin
                            rel_next = cmd.release_index[SLOT_W-1:0];
                            if (cmd.release_index < REL_W'(pool_eff))
                            begin
                                state_next = S_REL_RD;
                            end
                            else
                            begin
                                status_next = STAT_OK;
                                state_next  = S_RESP;
                            end
                        end
                        OP_CONTIG:
                        begin
                            if (cmd.count > CNT_W'(MAX_COUNT))
                            begin
                                status_next = STAT_NOSPACE;
                                state_next  = S_RESP;
                            end
                            else if (cmd.count == '0)
                            begin
                                status_next = STAT_OK;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        OP_SCATTER:
                        begin
                            if (scatter_lock_reg)
                            begin
                                status_next = STAT_NOTPERM;
                                state_next  = S_RESP;
                            end
                            else if (cmd.count > CNT_W'(MAX_SCATTERED))
                            begin
                                status_next = STAT_OVERLIMIT;
                                state_next  = S_RESP;
                            end
                            else if (cmd.count == '0)
                            begin
                                status_next = STAT_OK;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                // Reads stream one word per cycle; the scan unit sees each word
                // the cycle after its read.
                rd_addr = issue_reg[WADDR_W-1:0];
                if (issue_reg < ISSUE_W'(NUM_WORDS))
                begin
                    issue_next = issue_reg + ISSUE_W'(1);
                    pend_next  = 1'b1;
                end
                if (scan_res.hit)
                begin
                    lo_next     = scan_res.start;
                    wi_next     = scan_res.start[SLOT_W-1:BIT_W];
                    remain_next = cnt_reg;
                    state_next  = S_COMMIT_RD;
                end
                else if (last_proc_reg)
                begin
                    status_next = STAT_NOSPACE;
                    state_next  = S_RESP;
                end
            end

            S_COMMIT_RD:
            begin
                rd_addr    = wi_reg;
                state_next = S_COMMIT_LOAD;
            end

            S_COMMIT_LOAD:
            begin
                work_next  = rd_data;
                state_next = S_COMMIT_BIT;
            end

            S_COMMIT_BIT:
            begin
                if ((remain_reg == '0) || !pick_any)
                begin
                    wr_en = 1'b1;
                    if (remain_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        wi_next    = wi_reg + WADDR_W'(1);
                        state_next = S_COMMIT_RD;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_status_next     = STAT_OK;
                    out_index_next      = INDEX_W'({wi_reg, pick_bit});
                    out_ivalid_next     = 1'b1;
                    out_last_next       = (remain_reg == CNT_W'(1));
                    work_next[pick_bit] = 1'b1;
                    remain_next         = remain_reg - CNT_W'(1);
                end
            end

            S_REL_RD:
            begin
                rd_addr    = rel_reg[SLOT_W-1:BIT_W];
                state_next = S_REL_WR;
            end

            S_REL_WR:
            begin
                wr_en                  = 1'b1;
                wr_addr                = rel_reg[SLOT_W-1:BIT_W];
                wr_data                = rd_data;
                wr_data[rel_reg[BIT_W-1:0]] = 1'b0;
                status_next            = STAT_OK;
                state_next             = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_index_next  = '0;
                    out_ivalid_next = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pool_size_reg    <= POOL_W'(MAX_SLOTS);
            scatter_lock_reg <= 1'b0;
            issue_reg        <= '0;
            pend_reg         <= 1'b0;
            last_proc_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            remain_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            last_proc_reg <= pend_reg && (pend_word_reg == WADDR_W'(NUM_WORDS - 1));
            out_valid_reg <= out_valid_next;
            remain_reg    <= remain_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POOL_SIZE:    pool_size_reg    <= cfg_data;
                    REG_SCATTER_LOCK: scatter_lock_reg <= cfg_data[0];
                    default:          pool_size_reg    <= pool_size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        is_contig_reg  <= is_contig_next;
        cnt_reg        <= cnt_next;
        lo_reg         <= lo_next;
        wi_reg         <= wi_next;
        work_reg       <= work_next;
        rel_reg        <= rel_next;
        status_reg     <= status_next;
        pend_word_reg  <= issue_reg[WADDR_W-1:0];
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_ivalid_reg <= out_ivalid_next;
        out_last_reg   <= out_last_next;
    end

    assign cmd.ready       = (state_reg == S_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.status      = out_status_reg;
    assign res.slot_index  = out_index_reg;
    assign res.index_valid = out_ivalid_reg;
    assign res.last        = out_last_reg;

endmodule

@@ hw/rtl/bra_mem.sv @@
module bra_mem import bra_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [WADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0]  rd_data,
    input  logic               wr_en,
    input  logic [WADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0]  wr_data
);

    logic [WORD_W-1:0]    ram [NUM_WORDS];
    logic [WORD_W-1:0]    data_reg;
    logic [NUM_WORDS-1:0] valid_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram[wr_addr] <= wr_data;
        end
        data_reg <= ram[rd_addr];
    end

    // A word never written since reset reads as all free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? data_reg : '0;

endmodule

@@ hw/rtl/bra_scan.sv @@
module bra_scan import bra_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               word_en,
    input  logic [WADDR_W-1:0] word_idx,
    input  logic [WORD_W-1:0]  word,
    input  scan_ctl_t          ctl,
    output scan_res_t          res
);

    logic [CNT_W-1:0]  run_len_reg,   run_len_next;
    logic [SLOT_W-1:0] run_start_reg, run_start_next;
    logic [POOL_W-1:0] free_cnt_reg,  free_cnt_next;
    logic              found_reg,     found_next;

    always_comb
    begin
        logic [POOL_W-1:0] slot;
        logic              free;
        run_len_next   = run_len_reg;
        run_start_next = run_start_reg;
        free_cnt_next  = free_cnt_reg;
        found_next     = found_reg;
        for (int j = 0; j < WORD_W; j++)
        begin
            slot = POOL_W'({word_idx, BIT_W'(j)});
            free = !word[j] && (slot < ctl.pool);
            if (ctl.contig && !found_next)
            begin
                if (free)
                begin
                    if (run_len_next == '0)
                    begin
                        run_start_next = slot[SLOT_W-1:0];
                    end
                    run_len_next = run_len_next + CNT_W'(1);
                    if (run_len_next == ctl.cnt)
                    begin
                        found_next = 1'b1;
                    end
                end
                else
                begin
                    run_len_next = '0;
                end
            end
            if (!ctl.contig && free)
            begin
                free_cnt_next = free_cnt_next + POOL_W'(1);
            end
        end
        // Scattered: enough free slots seen so far means the request fits.
        if (!ctl.contig && (free_cnt_next >= POOL_W'(ctl.cnt)))
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg   <= '0;
            run_start_reg <= '0;
            free_cnt_reg  <= '0;
            found_reg     <= 1'b0;
        end
        else if (clear)
        begin
            run_len_reg   <= '0;
            run_start_reg <= '0;
            free_cnt_reg  <= '0;
            found_reg     <= 1'b0;
        end
        else if (word_en && !found_reg)
        begin
            run_len_reg   <= run_len_next;
            run_start_reg <= run_start_next;
            free_cnt_reg  <= free_cnt_next;
            found_reg     <= found_next;
        end
    end

    assign res.hit   = found_reg;
    assign res.start = run_start_reg;

endmodule

@@ tb/bra_alloc_checker.sv @@
`timescale 1ns / 1ps

module bra_alloc_checker import bra_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    bra_cmd_if                   cmd,
    bra_res_if                   res,
    output int                   error_count,
    output int                   results_due
);

    typedef struct {
        status_t            status;
        logic [INDEX_W-1:0] slot;
        logic               index_valid;
        logic               last;
    } slot_result_t;

    logic [MAX_SLOTS-1:0] slot_used;
    logic [POOL_W-1:0]    pool_size;
    logic                 scatter_lock;
    slot_result_t         awaiting[$];

    function automatic void push_result(status_t st, int slot, logic iv, logic lst);
        slot_result_t r;
        r.status      = st;
        r.slot        = slot[INDEX_W-1:0];
        r.index_valid = iv;
        r.last        = lst;
        awaiting.push_back(r);
    endfunction

    // Applies one command to the local bitmap and queues the results it must produce.
    function automatic void predict_alloc(logic [OP_W-1:0] op, logic [CNT_W-1:0] cnt,
                                          logic [REL_W-1:0] rel);
        int pool;
        int start;
        int run;
        int n;
        int picked[$];
        pool = (pool_size > MAX_SLOTS) ? MAX_SLOTS : int'(pool_size);
        if (op == OP_NONE)
        begin
            return;
        end
        if (op == OP_RELEASE)
        begin
            // Indices outside the pool are dropped silently.
            if (rel < pool)
            begin
                slot_used[rel] = 1'b0;
            end
            push_result(STAT_OK, 0, 1'b0, 1'b1);
            return;
        end
        // A scattered assign checks the contiguous-only mode before its limit.
        if (op == OP_SCATTER && scatter_lock)
        begin
            push_result(STAT_NOTPERM, 0, 1'b0, 1'b1);
            return;
        end
        if (op == OP_SCATTER && cnt > MAX_SCATTERED)
        begin
            push_result(STAT_OVERLIMIT, 0, 1'b0, 1'b1);
            return;
        end
        if (op == OP_CONTIG && cnt > MAX_COUNT)
        begin
            push_result(STAT_NOSPACE, 0, 1'b0, 1'b1);
            return;
        end
        if (cnt == 0)
        begin
            push_result(STAT_OK, 0, 1'b0, 1'b1);
            return;
        end
        if (op == OP_CONTIG)
        begin
            for (start = 0; start + cnt <= pool && picked.size() == 0; start++)
            begin
                run = 0;
                while (run < cnt && !slot_used[start + run])
                begin
                    run++;
                end
                if (run == cnt)
                begin
                    for (n = 0; n < cnt; n++)
                    begin
                        picked.push_back(start + n);
                    end
                end
            end
        end
        else
        begin
            for (start = 0; start < pool && picked.size() < cnt; start++)
            begin
                if (!slot_used[start])
                begin
                    picked.push_back(start);
                end
            end
        end
        // Too few slots found: the bitmap stays as it was.
        if (picked.size() < cnt)
        begin
            push_result(STAT_NOSPACE, 0, 1'b0, 1'b1);
            return;
        end
        for (n = 0; n < picked.size(); n++)
        begin
            slot_used[picked[n]] = 1'b1;
            push_result(STAT_OK, picked[n], 1'b1, n == picked.size() - 1);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slot_result_t want;
        if (!rst_n)
        begin
            slot_used    = '0;
            pool_size    = POOL_W'(MAX_SLOTS);
            scatter_lock = 1'b0;
            awaiting.delete();
            error_count = 0;
            results_due = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_POOL_SIZE)
                begin
                    pool_size = cfg_data[POOL_W-1:0];
                end
                else if (cfg_index == REG_SCATTER_LOCK)
                begin
                    scatter_lock = cfg_data[0];
                end
            end
            if (res.valid && res.ready)
            begin
                if (awaiting.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("%0t: result transfer with none pending: status %0d slot %0d",
                                 $realtime, res.status, res.slot_index);
                    end
                end
                else
                begin
                    want = awaiting.pop_front();
                    if (res.status !== want.status || res.slot_index !== want.slot ||
                        res.index_valid !== want.index_valid || res.last !== want.last)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("%0t: result mismatch (expected/actual): status %0d/%0d",
                                     $realtime, want.status, res.status);
                            $display("    slot %0d/%0d index_valid %0d/%0d last %0d/%0d",
                                     want.slot, res.slot_index, want.index_valid,
                                     res.index_valid, want.last, res.last);
                        end
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                predict_alloc(cmd.opcode, cmd.count, cmd.release_index);
            end
            results_due = awaiting.size();
        end
    end

endmodule

@@ tb/tb_bitmap_resource_allocator.sv @@
`timescale 1ns / 1ps

module tb_bitmap_resource_allocator;
    import bra_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   error_count;
    int                   results_due;
    bit                   quiet;
    bit                   hold_request;
    logic                 hold_rx;
    int                   pool_now;

    bra_cmd_if cmd();
    bra_res_if res();

    bitmap_resource_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .res       (res)
    );

    bra_alloc_checker alloc_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .res         (res),
        .error_count (error_count),
        .results_due (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random stall bursts, overridden by the long hold.
    initial
    begin : res_ready_drive
        int gap;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                res.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                res.ready <= 1'b0;
                gap = $urandom_range(1, 19);
                repeat (gap) @(posedge clk);
                res.ready <= !hold_rx;
            end
            else
            begin
                res.ready <= 1'b1;
            end
        end
    end

    // Holds the result side off long enough for the block to back up into its command port.
    initial
    begin : long_hold
        hold_rx = 1'b0;
        wait (hold_request);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge clk);
        hold_rx <= 1'b0;
    end

    task automatic send_cmd(opcode_t op, int cnt, int rel);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        cmd.valid         <= 1'b1;
        cmd.opcode        <= op;
        cmd.count         <= cnt[CNT_W-1:0];
        cmd.release_index <= rel[REL_W-1:0];
        do @(posedge clk); while (!cmd.ready);
    endtask

    // Waits until every predicted result has been seen and the block has gone quiet.
    task automatic settle();
        cmd.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int pick_count();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
        begin
            return $urandom_range(0, 127);
        end
        if (roll < 4)
        begin
            return $urandom_range(9, 20);
        end
        return $urandom_range(1, 8);
    endfunction

    function automatic int pick_index();
        int eff;
        eff = (pool_now > MAX_SLOTS) ? MAX_SLOTS : pool_now;
        if (eff == 0 || $urandom_range(0, 9) == 0)
        begin
            return $urandom_range(0, 65535);
        end
        return $urandom_range(0, eff - 1);
    endfunction

    task automatic random_items(int n);
        int k;
        int roll;
        for (k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                send_cmd(OP_CONTIG, pick_count(), $urandom_range(0, 65535));
            end
            else if (roll < 65)
            begin
                send_cmd(OP_SCATTER, pick_count(), $urandom_range(0, 65535));
            end
            else if (roll < 96)
            begin
                send_cmd(OP_RELEASE, $urandom_range(0, 127), pick_index());
            end
            else
            begin
                send_cmd(OP_NONE, $urandom_range(0, 127), $urandom_range(0, 65535));
            end
        end
    endtask

    initial
    begin : stimulus
        cmd.valid         = 1'b0;
        cmd.opcode        = OP_CONTIG;
        cmd.count         = '0;
        cmd.release_index = '0;
        cfg_we            = 1'b0;
        cfg_index         = REG_POOL_SIZE;
        cfg_data          = '0;
        rst_n             = 1'b0;
        quiet             = 1'b0;
        hold_request      = 1'b0;
        pool_now          = MAX_SLOTS;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full pool after reset: field extremes, no-space and over-limit errors, ignored releases.
        send_cmd(OP_CONTIG, 0, 0);
        send_cmd(OP_CONTIG, 64, 0);
        send_cmd(OP_CONTIG, 65, 0);
        send_cmd(OP_CONTIG, 127, 65535);
        send_cmd(OP_SCATTER, 0, 0);
        send_cmd(OP_SCATTER, 16, 0);
        send_cmd(OP_SCATTER, 17, 0);
        send_cmd(OP_SCATTER, 127, 0);
        send_cmd(OP_RELEASE, 0, 65535);
        send_cmd(OP_RELEASE, 127, 255);
        send_cmd(OP_RELEASE, 0, 5);
        send_cmd(OP_RELEASE, 0, 7);
        send_cmd(OP_SCATTER, 3, 0);
        send_cmd(OP_NONE, 127, 65535);
        send_cmd(OP_CONTIG, 64, 0);
        send_cmd(OP_CONTIG, 64, 0);
        send_cmd(OP_CONTIG, 64, 0);
        send_cmd(OP_RELEASE, 0, 0);
        send_cmd(OP_CONTIG, 1, 0);
        settle();

        // One-slot pool in contiguous-only mode.
        write_reg(REG_POOL_SIZE, 1);
        write_reg(REG_SCATTER_LOCK, 1);
        pool_now = 1;
        send_cmd(OP_RELEASE, 0, 0);
        send_cmd(OP_CONTIG, 1, 0);
        send_cmd(OP_CONTIG, 1, 0);
        send_cmd(OP_SCATTER, 1, 0);
        send_cmd(OP_SCATTER, 0, 0);
        settle();

        // Empty pool.
        write_reg(REG_POOL_SIZE, 0);
        write_reg(REG_SCATTER_LOCK, 0);
        pool_now = 0;
        send_cmd(OP_CONTIG, 1, 0);
        send_cmd(OP_CONTIG, 0, 0);
        send_cmd(OP_SCATTER, 2, 0);
        send_cmd(OP_RELEASE, 0, 0);
        settle();

        // Oversized pool setting saturates to the full pool; the long hold starts here.
        write_reg(REG_POOL_SIZE, 511);
        pool_now = 511;
        hold_request = 1'b1;
        random_items(40);
        settle();

        // Small pool so that fragmentation and no-space show up often.
        write_reg(REG_POOL_SIZE, 37);
        pool_now = 37;
        random_items(30);
        settle();

        write_reg(REG_POOL_SIZE, 200);
        write_reg(REG_SCATTER_LOCK, 1);
        pool_now = 200;
        random_items(20);
        settle();

        // Closing stretch at full rate on both sides.
        write_reg(REG_POOL_SIZE, MAX_SLOTS);
        write_reg(REG_SCATTER_LOCK, 0);
        pool_now = MAX_SLOTS;
        quiet = 1'b1;
        random_items(20);
        settle();

        if (error_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
